FILE: rtl/core/apc_pkg.sv
`default_nettype none
package apc_pkg;

  // Number format and sizes
  localparam int PeriodBits   = 10;
  localparam int RateFracBits = 32;
  localparam int SatIntBits   = 40;
  localparam int PayBits      = 49;

  localparam int VW   = SatIntBits + RateFracBits + 1;  // power value width
  localparam int PrW  = 64;                            // principal * rate
  localparam int XW   = PrW + VW;                      // numerator width
  localparam int LW   = 25;                            // multiplier limb width
  localparam int NL   = (VW + LW - 1) / LW;            // limbs per power value
  localparam int EW   = NL * LW;
  localparam int SW   = 2 * EW;
  localparam int HW   = PrW / 2;                       // numerator-side limb
  localparam int XPW  = HW + LW;
  localparam int XSW  = PrW + EW;
  localparam int ShW  = 16;                            // output 1/65536 scale

  localparam logic [VW-1:0] OneV = VW'(1) << RateFracBits;
  localparam logic [SW-1:0] CapW = SW'(1) << (SatIntBits + RateFracBits);

  localparam int InDataW  = ((2 * 32 + PeriodBits) + 7) / 8 * 8;
  localparam int OutDataW = ((PayBits + 2) + 7) / 8 * 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_RATE = 2'd1,
    ST_ZERO_PER  = 2'd2
  } status_e;

  typedef logic [NL*NL-1:0][2*LW-1:0] pps_t;
  typedef logic [2*NL-1:0][XPW-1:0]   xpps_t;

  // State of one item between squaring steps
  typedef struct packed {
    status_e             st;
    logic [PrW-1:0]      pr;
    logic [PeriodBits-1:0] n;
    logic [VW-1:0]       acc;
    logic [VW-1:0]       base;
  } pw_t;

  // Partial products of one squaring step
  typedef struct packed {
    status_e             st;
    logic [PrW-1:0]      pr;
    logic [PeriodBits-1:0] n;
    logic [VW-1:0]       acc;
    pps_t                ab;
    pps_t                bb;
  } pa_t;

  typedef struct packed {
    status_e        st;
    logic [VW-1:0]  den;
    xpps_t          pp;
  } xa_t;

  typedef struct packed {
    status_e             st;
    logic [VW-1:0]       den;
    logic [XW-1:0]       rem;
    logic [PayBits-1:0]  quo;
  } dv_t;

  function automatic pps_t pw_pp(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [EW-1:0] ae;
    logic [EW-1:0] be;
    pps_t          r;
    ae = EW'(a);
    be = EW'(b);
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        r[i*NL+j] = (2*LW)'(ae[i*LW +: LW]) * (2*LW)'(be[j*LW +: LW]);
      end
    end
    return r;
  endfunction

  // Sum the partial products, drop the fraction bits, clamp at the cap
  function automatic logic [VW-1:0] pw_sat(input pps_t pp);
    logic [SW-1:0] s;
    logic [SW-1:0] t;
    s = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        s = s + (SW'(pp[i*NL+j]) << (LW * (i + j)));
      end
    end
    t = s >> RateFracBits;
    if (t > CapW) begin
      t = CapW;
    end
    return t[VW-1:0];
  endfunction

  function automatic xpps_t x_pp(input logic [PrW-1:0] a, input logic [VW-1:0] b);
    logic [EW-1:0] be;
    xpps_t         r;
    be = EW'(b);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < NL; j++) begin
        r[i*NL+j] = XPW'(a[i*HW +: HW]) * XPW'(be[j*LW +: LW]);
      end
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] x_sum(input xpps_t pp);
    logic [XSW-1:0] s;
    s = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < NL; j++) begin
        s = s + (XSW'(pp[i*NL+j]) << (HW * i + LW * j));
      end
    end
    return s[XW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/annuity_payment_calculator.sv
// Level annuity payment: payment = P*r*F/(F-1), F = (1+r)^n, in 1/65536 units.
//
// Input channel (s_axis): one transaction carries principal, per-period rate
// (unsigned Q0.32) and period count. Output channel (m_axis): one transaction
// per input carries the truncated payment and a status code (ok, zero rate,
// zero periods; the last two give a zero payment).
//
// Throughput is one transaction per cycle unless the output buffer is full. A
// result passes one input stage with the principal*rate multiplier, ten
// square-and-multiply steps of two stages each (limb partial products, then
// sum and clamp), two stages for the numerator product, a restoring divider
// that settles one quotient bit per stage over 49 stages, and the output buffer.
//
// Reset clears every valid bit and the two-entry output buffer; data registers
// are not reset. When the receiver stalls, results collect in the output
// buffer; once both entries are full the whole pipeline holds and s_axis
// tready drops until a result is taken.
`default_nettype none
module annuity_payment_calculator
  import apc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [31:0] principal, [63:32] rate_per_period, [73:64] periods
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [48:0] payment, [50:49] status
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int DivSt = PayBits;

  logic en;  // advance the whole pipeline

  // Input stage and power-step pipeline
  pw_t  pw_q   [0:PeriodBits];
  logic pw_v_q [0:PeriodBits];
  pa_t  pa_q   [0:PeriodBits-1];
  logic pa_v_q [0:PeriodBits-1];

  logic [31:0]           in_p;
  logic [31:0]           in_r;
  logic [PeriodBits-1:0] in_n;
  pw_t                   pw0_d;

  assign in_p = s_axis_tdata_i[31:0];
  assign in_r = s_axis_tdata_i[63:32];
  assign in_n = s_axis_tdata_i[64 +: PeriodBits];

  always_comb begin
    pw0_d.pr   = PrW'(in_p) * PrW'(in_r);
    pw0_d.n    = in_n;
    pw0_d.acc  = OneV;
    pw0_d.base = OneV + VW'(in_r);
    if (in_r == '0) begin
      pw0_d.st = ST_ZERO_RATE;
    end else if (in_n == '0) begin
      pw0_d.st = ST_ZERO_PER;
    end else begin
      pw0_d.st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_v_q[0] <= 1'b0;
    end else if (en) begin
      pw_v_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q[0] <= pw0_d;
    end
  end

  for (genvar k = 0; k < PeriodBits; k++) begin : g_pow
    pa_t pa_d;
    pw_t pw_d;

    // Partial products of acc*base and base*base
    always_comb begin
      pa_d.st  = pw_q[k].st;
      pa_d.pr  = pw_q[k].pr;
      pa_d.n   = pw_q[k].n;
      pa_d.acc = pw_q[k].acc;
      pa_d.ab  = pw_pp(pw_q[k].acc, pw_q[k].base);
      pa_d.bb  = pw_pp(pw_q[k].base, pw_q[k].base);
    end

    // Fold the products; take acc*base only where this period bit is set
    always_comb begin
      pw_d.st   = pa_q[k].st;
      pw_d.pr   = pa_q[k].pr;
      pw_d.n    = pa_q[k].n;
      pw_d.acc  = pa_q[k].n[k] ? pw_sat(pa_q[k].ab) : pa_q[k].acc;
      pw_d.base = pw_sat(pa_q[k].bb);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pa_v_q[k]   <= 1'b0;
        pw_v_q[k+1] <= 1'b0;
      end else if (en) begin
        pa_v_q[k]   <= pw_v_q[k];
        pw_v_q[k+1] <= pa_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[k]   <= pa_d;
        pw_q[k+1] <= pw_d;
      end
    end
  end

  // Numerator P*r*F and denominator F - one
  xa_t  xa_q;
  logic xa_v_q;
  xa_t  xa_d;
  dv_t  dv_q   [0:DivSt];
  logic dv_v_q [0:DivSt];
  dv_t  dv0_d;

  always_comb begin
    xa_d.st  = pw_q[PeriodBits].st;
    xa_d.den = pw_q[PeriodBits].acc - OneV;
    xa_d.pp  = x_pp(pw_q[PeriodBits].pr, pw_q[PeriodBits].acc);
  end

  always_comb begin
    dv0_d.st  = xa_q.st;
    dv0_d.den = xa_q.den;
    dv0_d.rem = x_sum(xa_q.pp);
    dv0_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xa_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      xa_v_q    <= pw_v_q[PeriodBits];
      dv_v_q[0] <= xa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q     <= xa_d;
      dv_q[0]  <= dv0_d;
    end
  end

  // Restoring division by den * 2^16, most significant quotient bit first
  for (genvar i = 0; i < DivSt; i++) begin : g_div
    localparam int J = DivSt - 1 - i;
    logic [XW-1:0] dsh;
    logic [XW:0]   diff;
    dv_t           dv_d;

    always_comb begin
      dsh  = (XW'(dv_q[i].den) << ShW) << J;
      diff = {1'b0, dv_q[i].rem} - {1'b0, dsh};
      dv_d = dv_q[i];
      if (!diff[XW]) begin
        dv_d.rem    = diff[XW-1:0];
        dv_d.quo[J] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[i+1] <= dv_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[i+1] <= dv_d;
      end
    end
  end

  // Two-entry output buffer
  logic [OutDataW-1:0] res;
  logic [OutDataW-1:0] slot0_q;
  logic [OutDataW-1:0] slot1_q;
  logic [OutDataW-1:0] slot0_d;
  logic [OutDataW-1:0] slot1_d;
  logic [1:0]          cnt_q;
  logic [1:0]          cnt_d;
  logic                push;
  logic                pop;
  logic                wr_idx;

  always_comb begin
    res = '0;
    res[PayBits-1:0] = (dv_q[DivSt].st == ST_OK) ? dv_q[DivSt].quo : '0;
    res[PayBits +: 2] = dv_q[DivSt].st;
  end

  assign en     = (cnt_q != 2'd2);
  assign push   = en && dv_v_q[DivSt];
  assign pop    = m_axis_tvalid_o && m_axis_tready_i;
  assign wr_idx = (cnt_q[0] && !pop);
  assign cnt_d  = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift the buffer on a pop, then drop a new result into the free slot
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push) begin
      if (wr_idx) begin
        slot1_d = res;
      end else begin
        slot0_d = res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = slot0_q;

endmodule
`default_nettype wire

FILE: rtl/core/apc_checker.sv
`default_nettype none
module apc_checker
  import apc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [InDataW-1:0]  s_axis_tdata_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0] st;
  assign st = m_axis_tdata_o[PayBits +: 2];

  // Hold a result until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (st == ST_OK || st == ST_ZERO_RATE || st == ST_ZERO_PER))
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st != ST_OK |-> m_axis_tdata_o[PayBits-1:0] == '0)
    else $error("nonzero payment with error status");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:PayBits+2] == '0)
    else $error("padding bits set");

endmodule

bind annuity_payment_calculator apc_checker u_apc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
